@@ design/assert_macros.svh @@
// Assertion shorthands shared by the conversion block.
// All checks sample on the rising clock edge and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define BDC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define BDC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define BDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bdc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types, constants and helpers for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package bdc_pkg;

   // Width of the value field on the request channel.
   localparam int IN_WIDTH = 32;
   // Default width of the converted number.
   localparam int VALUE_BITS_DEFAULT = 32;
   // Default number of entries between the converter and the emitter.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // ASCII character field.
   localparam int CHAR_WIDTH = 6;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = 6'd57;

   // Decimal digits needed for the largest number of the given width:
   // floor(bits * log10(2)) + 1.
   function automatic int digits_for(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

   // Converter sequencer states.
   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SHIFT,
      FR_PUSH
   } front_state_type;

endpackage

@@ design/bdc_front.sv @@
// ----------------------------------------------------------------------------
// bdc_front
// Accepts a value and converts it to packed BCD with a shift-and-add-3
// sequencer, one input bit per cycle; tags the result with the index of its
// most significant nonzero digit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdc_front #(
   parameter int VALUE_BITS = bdc_pkg::VALUE_BITS_DEFAULT,
   parameter int DIGITS     = bdc_pkg::digits_for(bdc_pkg::VALUE_BITS_DEFAULT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bdc_pkg::IN_WIDTH-1:0]  req_value,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [$clog2(DIGITS)-1:0]     push_top,
   output logic [4*DIGITS-1:0]           push_bcd
);

   localparam int IN_BITS = (VALUE_BITS < bdc_pkg::IN_WIDTH) ? VALUE_BITS : bdc_pkg::IN_WIDTH;
   localparam int CNT_W   = $clog2(VALUE_BITS);
   localparam int BCD_W   = 4 * DIGITS;
   localparam int IDX_W   = $clog2(DIGITS);

   bdc_pkg::front_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]         bcd_ff, bcd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [BCD_W-1:0]         adj;
   logic [IDX_W-1:0]         top;

   // Add 3 to every digit of 5 or more before the shift.
   always_comb begin
      logic [3:0] d;
      d   = '0;
      adj = '0;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
      end
   end

   // Index of the highest nonzero digit; zero when the value is zero.
   always_comb begin
      top = '0;
      for (int i = 1; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            top = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdc_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         bdc_pkg::FR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bin_in   = VALUE_BITS'(req_value[IN_BITS-1:0]);
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               state_in = bdc_pkg::FR_SHIFT;
            end
         end
         bdc_pkg::FR_SHIFT: begin
            bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = bdc_pkg::FR_PUSH;
            end
         end
         bdc_pkg::FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = bdc_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = bdc_pkg::FR_IDLE;
         end
      endcase
   end

   assign push_top = top;
   assign push_bcd = bcd_ff;

   `BDC_ASSERT_NEXT(a_push_after_shift, state_ff == bdc_pkg::FR_SHIFT && cnt_ff == '0, state_ff == bdc_pkg::FR_PUSH, "conversion did not end in push")
   `BDC_ASSERT_IMPLIES(a_push_origin, state_ff == bdc_pkg::FR_PUSH, $past(state_ff) == bdc_pkg::FR_SHIFT || $past(state_ff) == bdc_pkg::FR_PUSH, "push entered without a conversion")

endmodule

@@ design/bdc_queue.sv @@
// ----------------------------------------------------------------------------
// bdc_queue
// Small first-in first-out buffer between the converter and the emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BDC_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above depth")

endmodule

@@ design/bdc_back.sv @@
// ----------------------------------------------------------------------------
// bdc_back
// Takes converted BCD entries and emits their digits as ASCII, most
// significant first, one per cycle while the receiver is ready, through a
// registered output stage.
`include "assert_macros.svh"

module bdc_back #(
   parameter int DIGITS = bdc_pkg::digits_for(bdc_pkg::VALUE_BITS_DEFAULT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  logic [$clog2(DIGITS)-1:0]       pop_top,
   input  logic [4*DIGITS-1:0]             pop_bcd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bdc_pkg::CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic                            rsp_last
);

   localparam int IDX_W = $clog2(DIGITS);

   logic                           active_ff, active_in;
   logic [4*DIGITS-1:0]            bcd_ff, bcd_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic [bdc_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           load;

   assign pop_ready = !active_ff;
   assign load      = active_ff && (!valid_ff || rsp_ready);

   always_comb begin
      active_in = active_ff;
      bcd_in    = bcd_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (pop_valid && pop_ready) begin
         bcd_in    = pop_bcd;
         idx_in    = pop_top;
         active_in = 1'b1;
      end
      if (load) begin
         char_in  = bdc_pkg::ASCII_ZERO +
                    {{(bdc_pkg::CHAR_WIDTH-4){1'b0}}, bcd_ff[idx_ff*4 +: 4]};
         last_in  = (idx_ff == '0);
         valid_in = 1'b1;
         if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      bcd_ff  <= bcd_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

   `BDC_ASSERT_NEXT(a_no_gap_in_value, valid_ff && !last_ff, valid_ff, "digit stream broken before last")
   `BDC_ASSERT_IMPLIES(a_char_range, valid_ff, char_ff >= bdc_pkg::ASCII_ZERO && char_ff <= bdc_pkg::ASCII_NINE, "digit character out of range")

endmodule

@@ design/binary_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to its decimal text, one ASCII digit per
// transaction, most significant first, with a last flag on the final digit.
// ----------------------------------------------------------------------------
// Each req_ transaction carries one unsigned number; only its low VALUE_BITS
// bits count. The block answers with its decimal digits as rsp_ transactions,
// most significant digit first, leading zeros dropped, rsp_last high on the
// final digit; zero gives a single '0'. The converter accepts a value, runs one
// shift-and-add-3 step per input bit and hands the result off, and takes no new
// value before that hand-off. A two-entry queue sits between the converter and
// the digit emitter, so the next value converts while the digits of earlier
// ones still drain at one per cycle while the receiver is ready, with the
// emitter idle while it takes each new entry. There is no configuration and no clearing pass.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS  = bdc_pkg::VALUE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = bdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bdc_pkg::IN_WIDTH-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bdc_pkg::CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic                            rsp_last
);

   // Digits needed for the widest value, and the index width to reach them.
   localparam int DIGITS  = bdc_pkg::digits_for(VALUE_BITS);
   localparam int IDX_W   = $clog2(DIGITS);
   localparam int ENTRY_W = IDX_W + 4 * DIGITS;

   // Converter to queue.
   logic                push_valid;
   logic                push_ready;
   logic [IDX_W-1:0]    push_top;
   logic [4*DIGITS-1:0] push_bcd;

   // Queue to emitter.
   logic                pop_valid;
   logic                pop_ready;
   logic [ENTRY_W-1:0]  pop_data;

   // Convert: accept a value, shift it into BCD, find the leading digit.
   bdc_front #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_top   (push_top),
      .push_bcd   (push_bcd)
   );

   // Hold finished conversions so converter and emitter stall on their own.
   bdc_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_top, push_bcd}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Emit digits from the leading one down to the units digit.
   bdc_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_top        (pop_data[ENTRY_W-1 -: IDX_W]),
      .pop_bcd        (pop_data[4*DIGITS-1:0]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary to decimal ASCII converter: every value
// sent is turned into its expected digit sequence, and each digit that
// leaves the block is compared with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS = bdc_pkg::VALUE_BITS_DEFAULT;
   // Longest time from a value entering to its last digit leaving, without
   // any stall on the result side: conversion, queue and emitter slack.
   localparam int DRAIN_CYCLES =
      VALUE_BITS + 2 + 3 * (bdc_pkg::digits_for(VALUE_BITS) + 2);

   // One digit character as it should appear on the result channel.
   typedef struct packed {
      logic [bdc_pkg::CHAR_WIDTH-1:0] digit_char;
      logic                           last;
   } ascii_digit_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [bdc_pkg::IN_WIDTH-1:0]    req_value;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [bdc_pkg::CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                            rsp_last;

   // Digits still owed by the block, oldest first.
   ascii_digit_type pending_digits[$];

   int  mismatches     = 0;
   int  values_sent    = 0;
   int  digits_checked = 0;
   int  zero_values    = 0;
   int  ten_digit_vals = 0;
   // High while a test wants both sides running flat out.
   bit  no_idle        = 1'b0;

   binary_to_decimal_ascii #(
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Decimal digit predictor
   // -------------------------------------------------------------------------
   // Mask the value to the converted width, peel off decimal digits least
   // significant first, then queue them most significant first with the last
   // flag on the units digit. Zero yields one '0'.
   function automatic void queue_decimal_digits(input logic [bdc_pkg::IN_WIDTH-1:0] value);
      logic [63:0]     remaining;
      logic [3:0]      digits[20];
      int              count;
      ascii_digit_type entry;
      remaining = 64'(value);
      if (VALUE_BITS < 64)
         remaining = remaining & ((64'd1 << VALUE_BITS) - 64'd1);
      count = 0;
      if (remaining == 64'd0) begin
         digits[0] = 4'd0;
         count = 1;
         zero_values++;
      end else begin
         while (remaining != 64'd0 && count < 20) begin
            digits[count] = 4'(remaining % 64'd10);
            remaining     = remaining / 64'd10;
            count++;
         end
      end
      if (count == 10)
         ten_digit_vals++;
      for (int k = count - 1; k >= 0; k--) begin
         entry.digit_char = bdc_pkg::ASCII_ZERO + bdc_pkg::CHAR_WIDTH'(digits[k]);
         entry.last       = (k == 0);
         pending_digits.push_back(entry);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Transaction monitor and digit checker
   // -------------------------------------------------------------------------
   // Sample both channels at the clock edge. Predict before checking so a
   // value and a digit that move in the same cycle are handled in order.
   always @(posedge clock) begin : check_digits
      ascii_digit_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_decimal_digits(req_value);
            values_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            digits_checked++;
            if (pending_digits.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                        $time, rsp_digit_char, rsp_last);
            end else begin
               want = pending_digits.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  mismatches++;
                  $display("%0t: digit_char mismatch: expected %0d, got %0d",
                           $time, want.digit_char, rsp_digit_char);
               end
               if (rsp_last !== want.last) begin
                  mismatches++;
                  $display("%0t: last mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   // Stall the result side about a quarter of the time, except in a burst.
   always @(posedge clock)
      rsp_ready <= no_idle || ($urandom_range(99) >= 25);

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   // Offer one value and hold it until accepted. Called at a clock edge; the
   // valid line is only dropped when an idle gap is inserted, so it is never
   // lowered and raised in the same step.
   task automatic send_value(input logic [bdc_pkg::IN_WIDTH-1:0] value);
      if (!no_idle && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 25)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Draw a value with a uniformly chosen digit count, so short numbers are
   // as common as long ones; now and then take a raw 32-bit word or zero.
   function automatic logic [bdc_pkg::IN_WIDTH-1:0] pick_value(input bit favor_wide);
      longint lo;
      longint hi;
      int     width_digits;
      int     roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return '0;
      if (roll < 13)
         return $urandom;
      width_digits = favor_wide ? $urandom_range(8, 10) : $urandom_range(1, 10);
      lo = 1;
      for (int k = 1; k < width_digits; k++)
         lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF)
         hi = 64'hFFFF_FFFF;
      return bdc_pkg::IN_WIDTH'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
   endfunction

   // Boundaries around every power of ten, all digits, the sign-bit edge and
   // the full-scale word, with zero first.
   task automatic test_corner_values();
      logic [bdc_pkg::IN_WIDTH-1:0] corner_values[25] = '{
         32'd0,          32'd1,          32'd9,          32'd10,
         32'd99,         32'd100,        32'd999,        32'd1000,
         32'd9999,       32'd10000,      32'd99999,      32'd100000,
         32'd999999,     32'd1000000,    32'd9999999,    32'd10000000,
         32'd99999999,   32'd100000000,  32'd999999999,  32'd1000000000,
         32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4294967294,
         32'd4294967295
      };
      foreach (corner_values[k])
         send_value(corner_values[k]);
   endtask

   // Random values of every length with random idling on both sides.
   task automatic test_random_lengths();
      repeat (200)
         send_value(pick_value(1'b0));
   endtask

   // Back-to-back long numbers with no idling anywhere, to keep the converter
   // busy with the digit emitter draining behind it.
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (105)
         send_value(pick_value(1'b1));
      no_idle = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_corner_values();
      test_random_lengths();
      test_back_to_back();
      req_valid <= 1'b0;

      // Wait out every owed digit, then watch a while for strays.
      while (pending_digits.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d zero, %0d of ten digits) into %0d checked digits,",
               values_sent, zero_values, ten_digit_vals, digits_checked);
      $display("under random stalls on both channels and one stall-free burst.");
      if (mismatches == 0 && pending_digits.size() == 0) begin
         $display("binary_to_decimal_ascii verification clean");
      end else begin
         $display("binary_to_decimal_ascii verification failed");
      end
      $finish;
   end

   // Stop a hung run; a correct one ends far sooner.
   initial begin
      #2_000_000;
      $display("Timeout with %0d digits still owed", pending_digits.size());
      $display("binary_to_decimal_ascii verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/bdc_pkg.sv
design/bdc_front.sv
design/bdc_queue.sv
design/bdc_back.sv
design/binary_to_decimal_ascii.sv
bench/testbench.sv
